>>> src/lfrc_pkg.sv
// Shared types and constants for the link frame receive classifier.
package lfrc_pkg;

	localparam logic [7:0] SIGN_MARK   = 8'hFE;
	localparam logic [7:0] MAJ_PAIRING = 8'hAA;
	localparam logic [7:0] MAJ_CONTROL = 8'hCC;
	localparam logic [7:0] MAJ_DATA    = 8'hDD;

	localparam logic [7:0] MIN_HANDSHAKE = 8'hBA;
	localparam logic [7:0] MIN_PAIR      = 8'hBB;
	localparam logic [7:0] MIN_ID_CHANGE = 8'hBE;
	localparam logic [7:0] MIN_OWN_AA    = 8'hAA;
	localparam logic [7:0] MIN_OWN_AB    = 8'hAB;
	localparam logic [7:0] MIN_OWN_AE    = 8'hAE;
	localparam logic [7:0] MIN_OWN_AC    = 8'hAC;
	localparam logic [7:0] MIN_ACK       = 8'hBA;

	localparam logic [7:0] SUM_GOOD = 8'hFF;

	localparam int unsigned OUT_DATA_W = 80;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_NO_SIGN = 2'd1,
		STATUS_BAD_MSG = 2'd2
	} frame_status_t;

	typedef enum logic [2:0] {
		KIND_NONE      = 3'd0,
		KIND_HANDSHAKE = 3'd1,
		KIND_PAIR      = 3'd2,
		KIND_ID_CHANGE = 3'd3,
		KIND_ACK       = 3'd4,
		KIND_OWN_CMD   = 3'd5,
		KIND_DATA      = 3'd6
	} frame_kind_t;

	// Frame summary including the byte being processed.
	typedef struct packed {
		logic [7:0]  sign_byte;
		logic [7:0]  major_code;
		logic [7:0]  minor_code;
		logic [31:0] word_at_four;
		logic [31:0] word_at_eight;
		logic [7:0]  running_sum;
		logic        under_four;
		logic        under_eight;
		logic [7:0]  frame_length;
	} frame_sum_t;

	typedef struct packed {
		frame_status_t status;
		frame_kind_t   kind;
	} frame_class_t;

endpackage

>>> src/lfrc_frame_acc.sv
// Per-frame accumulator: byte sum, saturating count and captured header fields.
module lfrc_frame_acc
	import lfrc_pkg::*;
#(
	parameter int unsigned COUNT_LIMIT = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [7:0] rx_byte,
	input  logic       last_byte,
	output frame_sum_t summary
);

	localparam int unsigned CW = $clog2(COUNT_LIMIT + 1);

	logic [CW-1:0] count_q, count_d;
	logic [7:0]    sum_q, sign_q, major_q, minor_q;
	logic [31:0]   word4_q, word8_q;
	logic [7:0]    sign_d, major_d, minor_d;
	logic [31:0]   word4_d, word8_d;
	logic [4:0]    lane;

	assign lane = {count_q[1:0], 3'b000};

	always_comb begin
		sign_d  = sign_q;
		major_d = major_q;
		minor_d = minor_q;
		word4_d = word4_q;
		word8_d = word8_q;
		if (count_q == CW'(0)) begin
			sign_d = rx_byte;
		end else if (count_q == CW'(2)) begin
			major_d = rx_byte;
		end else if (count_q == CW'(3)) begin
			minor_d = rx_byte;
		end else if (count_q >= CW'(4) && count_q < CW'(8)) begin
			word4_d[lane +: 8] = rx_byte;
		end else if (count_q >= CW'(8) && count_q < CW'(12)) begin
			word8_d[lane +: 8] = rx_byte;
		end
		count_d = (count_q < CW'(COUNT_LIMIT)) ? count_q + CW'(1) : count_q;
	end

	always_comb begin
		summary.sign_byte     = sign_d;
		summary.major_code    = major_d;
		summary.minor_code    = minor_d;
		summary.word_at_four  = word4_d;
		summary.word_at_eight = word8_d;
		summary.running_sum   = sum_q + rx_byte;
		summary.under_four    = count_d < CW'(4);
		summary.under_eight   = count_d < CW'(8);
		summary.frame_length  = 8'(count_d);
	end

	// Clear everything after the final byte so the next byte opens a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sign_q  <= '0;
			major_q <= '0;
			minor_q <= '0;
			word4_q <= '0;
			word8_q <= '0;
		end else if (go) begin
			if (last_byte) begin
				count_q <= '0;
				sum_q   <= '0;
				sign_q  <= '0;
				major_q <= '0;
				minor_q <= '0;
				word4_q <= '0;
				word8_q <= '0;
			end else begin
				count_q <= count_d;
				sum_q   <= summary.running_sum;
				sign_q  <= sign_d;
				major_q <= major_d;
				minor_q <= minor_d;
				word4_q <= word4_d;
				word8_q <= word8_d;
			end
		end
	end

endmodule

>>> src/lfrc_classify.sv
// Frame classification: status and kind from a completed frame summary.
module lfrc_classify
	import lfrc_pkg::*;
(
	input  frame_sum_t   summary,
	output frame_class_t verdict
);

	frame_kind_t kind;

	always_comb begin
		kind = KIND_NONE;
		case (summary.major_code)
			MAJ_PAIRING: begin
				case (summary.minor_code)
					MIN_HANDSHAKE: kind = KIND_HANDSHAKE;
					MIN_PAIR:      kind = KIND_PAIR;
					MIN_ID_CHANGE: kind = KIND_ID_CHANGE;
					MIN_OWN_AA, MIN_OWN_AB, MIN_OWN_AE: kind = KIND_OWN_CMD;
					default:       kind = KIND_NONE;
				endcase
			end
			MAJ_CONTROL: begin
				case (summary.minor_code)
					MIN_ACK:                kind = KIND_ACK;
					MIN_OWN_AC, MIN_OWN_AB: kind = KIND_OWN_CMD;
					default:                kind = KIND_NONE;
				endcase
			end
			MAJ_DATA: kind = KIND_DATA;
			default:  kind = KIND_NONE;
		endcase
	end

	always_comb begin
		verdict.status = STATUS_OK;
		verdict.kind   = KIND_NONE;
		if (summary.sign_byte != SIGN_MARK) begin
			verdict.status = STATUS_NO_SIGN;
		end else if (summary.under_four) begin
			verdict.status = STATUS_BAD_MSG;
		end else if (summary.minor_code != MIN_OWN_AA && summary.under_eight) begin
			verdict.status = STATUS_BAD_MSG;
		end else if (summary.running_sum != SUM_GOOD) begin
			verdict.status = STATUS_BAD_MSG;
		end else if (kind == KIND_NONE) begin
			verdict.status = STATUS_BAD_MSG;
		end else begin
			verdict.kind = kind;
		end
	end

endmodule

>>> src/link_frame_rx_classifier_unit.sv
// Top level of the link frame receive classifier.
//
// Usage
//   Slave stream (s_*): one frame byte per transaction in s_tdata[7:0], offset
//   zero first, with s_tlast high on the final byte of the frame.
//   Master stream (m_*): one status transaction per frame, issued for the
//   transaction that carried s_tlast; other bytes produce no output.
// Throughput
//   One byte per cycle while no final byte waits on a busy output register. A
//   byte is held in an input register, then folded into the frame state while
//   the classifier result for a final byte is written to the output register,
//   which drives m_tvalid.
// Stall behaviour
//   While m_tvalid is high and m_tready low, the output register holds its
//   transaction. Non-final bytes keep flowing; a final byte waits in the input
//   register, and s_tready drops until the output register frees up.
// Reset
//   arst_n clears the pipeline valids and all frame state; the first byte
//   after reset starts a new frame. The byte count saturates at COUNT_LIMIT;
//   frame_length reports its low eight bits.
module link_frame_rx_classifier_unit
	import lfrc_pkg::*;
#(
	parameter int unsigned COUNT_LIMIT = 255
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  logic                  s_tlast,   // last_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] frame_status, [4:2] frame_kind, [36:5] first_word,
	// [68:37] second_word, [76:69] frame_length, [79:77] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic         out_free;
	logic         go;
	frame_sum_t   summary;
	frame_class_t verdict;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || m_tready;
	// Advance the held byte: non-final bytes always, final bytes only with room.
	assign go       = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	lfrc_frame_acc #(
		.COUNT_LIMIT(COUNT_LIMIT)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.rx_byte  (byte_s1),
		.last_byte(last_s1),
		.summary  (summary)
	);

	lfrc_classify u_cls (
		.summary(summary),
		.verdict(verdict)
	);

	// Load a result on the final byte; drop the valid once the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			out_data_q <= {3'b000,
			               summary.frame_length,
			               summary.word_at_eight,
			               summary.word_at_four,
			               verdict.kind,
			               verdict.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> verif/link_frame_rx_classifier_unit_tb.sv
// Self-checking testbench for the link frame receive classifier: directed and random frames.
module link_frame_rx_classifier_unit_tb
	import lfrc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COUNT_LIMIT    = 255;
	localparam int          TOTAL_ITEMS    = 600;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          DRAIN_CYCLES   = 8;

	typedef struct packed {
		frame_status_t status;
		frame_kind_t   kind;
		logic [31:0]   first_word;
		logic [31:0]   second_word;
		logic [7:0]    frame_length;
	} frame_result_t;

	// One byte transaction; rows with a typed result carry it in want.
	typedef struct {
		logic [7:0]    rx_byte;
		logic          last_byte;
		bit            typed;
		frame_result_t want;
	} rx_byte_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata  = 8'h00;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	rx_byte_row_t  frame_bytes_q [$];
	frame_result_t pending_class_q [$];
	int            stim_pos     = 0;
	int            quiet_cycles = 0;
	int            drain_count  = 0;
	int            errors       = 0;

	// Shadow of the frame being received.
	int unsigned rx_count = 0;
	logic [7:0]  rx_sum   = 8'h00;
	logic [7:0]  rx_sign  = 8'h00;
	logic [7:0]  rx_major = 8'h00;
	logic [7:0]  rx_minor = 8'h00;
	logic [31:0] rx_w4    = 32'h0;
	logic [31:0] rx_w8    = 32'h0;

	link_frame_rx_classifier_unit #(
		.COUNT_LIMIT(COUNT_LIMIT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic frame_kind_t kind_for_codes(input logic [7:0] major, input logic [7:0] minor);
		frame_kind_t kind;
		kind = KIND_NONE;
		if (major == MAJ_PAIRING) begin
			case (minor)
				MIN_HANDSHAKE: kind = KIND_HANDSHAKE;
				MIN_PAIR:      kind = KIND_PAIR;
				MIN_ID_CHANGE: kind = KIND_ID_CHANGE;
				MIN_OWN_AA, MIN_OWN_AB, MIN_OWN_AE: kind = KIND_OWN_CMD;
				default:       kind = KIND_NONE;
			endcase
		end else if (major == MAJ_CONTROL) begin
			case (minor)
				MIN_ACK:                kind = KIND_ACK;
				MIN_OWN_AC, MIN_OWN_AB: kind = KIND_OWN_CMD;
				default:                kind = KIND_NONE;
			endcase
		end else if (major == MAJ_DATA) begin
			kind = KIND_DATA;
		end
		return kind;
	endfunction

	// Fold one byte into the shadow frame; on the final byte classify and clear.
	function automatic bit classify_byte(input logic [7:0] b, input logic last,
			output frame_result_t res);
		int unsigned off;
		frame_kind_t kind;
		res = '0;
		off = rx_count;
		rx_sum = rx_sum + b;
		if (off == 0)
			rx_sign = b;
		else if (off == 2)
			rx_major = b;
		else if (off == 3)
			rx_minor = b;
		else if (off >= 4 && off < 8)
			rx_w4[8*(off-4) +: 8] = b;
		else if (off >= 8 && off < 12)
			rx_w8[8*(off-8) +: 8] = b;
		if (rx_count < COUNT_LIMIT)
			rx_count++;
		if (!last)
			return 1'b0;

		kind = KIND_NONE;
		if (rx_sign != SIGN_MARK) begin
			res.status = STATUS_NO_SIGN;
		end else if (rx_count < 4) begin
			res.status = STATUS_BAD_MSG;
		end else if (rx_minor != MIN_OWN_AA && rx_count < 8) begin
			res.status = STATUS_BAD_MSG;
		end else if (rx_sum != SUM_GOOD) begin
			res.status = STATUS_BAD_MSG;
		end else begin
			kind = kind_for_codes(rx_major, rx_minor);
			res.status = (kind == KIND_NONE) ? STATUS_BAD_MSG : STATUS_OK;
		end
		res.kind         = kind;
		res.first_word   = rx_w4;
		res.second_word  = rx_w8;
		res.frame_length = rx_count[7:0];

		rx_count = 0;
		rx_sum   = 8'h00;
		rx_sign  = 8'h00;
		rx_major = 8'h00;
		rx_minor = 8'h00;
		rx_w4    = 32'h0;
		rx_w8    = 32'h0;
		return 1'b1;
	endfunction

	// Sign byte first, known codes most of the time, offset 1 trimmed so the sum closes.
	task automatic queue_good_frame(input int len);
		logic [7:0] fb [$];
		logic [7:0] total;
		int spot;
		for (int i = 0; i < len; i++)
			fb.push_back(8'($urandom));
		fb[0] = SIGN_MARK;
		case ($urandom_range(0, 3))
			0: fb[2] = MAJ_PAIRING;
			1: fb[2] = MAJ_CONTROL;
			2: fb[2] = MAJ_DATA;
			default: ;
		endcase
		if (len < 8 && $urandom_range(0, 3) != 0) begin
			fb[3] = MIN_OWN_AA;
		end else if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 5))
				0: fb[3] = MIN_HANDSHAKE;
				1: fb[3] = MIN_PAIR;
				2: fb[3] = MIN_ID_CHANGE;
				3: fb[3] = MIN_OWN_AB;
				4: fb[3] = MIN_OWN_AE;
				default: fb[3] = MIN_OWN_AC;
			endcase
		end
		total = 8'h00;
		for (int i = 0; i < len; i++)
			if (i != 1)
				total = total + fb[i];
		fb[1] = SUM_GOOD - total;
		// break one frame in ten so the checksum path sees failures too
		if ($urandom_range(0, 9) == 0) begin
			spot = $urandom_range(0, len - 1);
			fb[spot] = fb[spot] ^ 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < len; i++)
			frame_bytes_q.push_back('{fb[i], i == len - 1, 1'b0, '0});
	endtask

	initial begin : build_and_reset
		int len;
		logic [7:0] b;
		frame_bytes_q = '{
			// lone byte without the sign mark
			'{8'h00, 1'b1, 1'b1, '{STATUS_NO_SIGN, KIND_NONE, 32'h0, 32'h0, 8'd1}},
			// two bytes: too short
			'{8'hFE, 1'b0, 1'b0, '0},
			'{8'h01, 1'b1, 1'b1, '{STATUS_BAD_MSG, KIND_NONE, 32'h0, 32'h0, 8'd2}},
			// four bytes with minor AA: allowed short, closes the sum
			'{8'hFE, 1'b0, 1'b0, '0},
			'{8'hAD, 1'b0, 1'b0, '0},
			'{8'hAA, 1'b0, 1'b0, '0},
			'{8'hAA, 1'b1, 1'b0, '0},
			// five bytes, minor not AA: rejected, first word only partly filled
			'{8'hFE, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'hCC, 1'b0, 1'b0, '0},
			'{8'hBA, 1'b0, 1'b0, '0},
			'{8'h5A, 1'b1, 1'b1, '{STATUS_BAD_MSG, KIND_NONE, 32'h5A, 32'h0, 8'd5}},
			// full data frame, both words all ones
			'{8'hFE, 1'b0, 1'b0, '0},
			'{8'h2C, 1'b0, 1'b0, '0},
			'{8'hDD, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b1,
				'{STATUS_OK, KIND_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd12}}
		};

		// a frame that runs past the count limit
		queue_good_frame($urandom_range(COUNT_LIMIT + 1, COUNT_LIMIT + 8));

		while (frame_bytes_q.size() < TOTAL_ITEMS) begin
			if ($urandom_range(0, 99) < 70) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 7) : $urandom_range(8, 16);
				queue_good_frame(len);
			end else begin
				// noise: random bytes, the first one a sign mark in half of the noise frames
				len = $urandom_range(1, 14);
				for (int i = 0; i < len; i++) begin
					b = 8'($urandom);
					if (i == 0 && $urandom_range(0, 1) == 1)
						b = SIGN_MARK;
					frame_bytes_q.push_back('{b, i == len - 1, 1'b0, '0});
				end
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Check results, predict accepted bytes and drive both sides of the handshake.
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t calc;
		frame_result_t want;
		bit made;
		bit send;
		int phase;
		int send_idle;
		int recv_idle;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status       = frame_status_t'(m_tdata[1:0]);
				got.kind         = frame_kind_t'(m_tdata[4:2]);
				got.first_word   = m_tdata[36:5];
				got.second_word  = m_tdata[68:37];
				got.frame_length = m_tdata[76:69];
				if (pending_class_q.size() == 0) begin
					$error("result transaction with no expectation waiting");
					errors++;
				end else begin
					want = pending_class_q.pop_front();
					if (got.status !== want.status) begin
						$error("frame_status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
					if (got.kind !== want.kind) begin
						$error("frame_kind: expected %0d, got %0d", want.kind, got.kind);
						errors++;
					end
					if (got.first_word !== want.first_word) begin
						$error("first_word: expected %h, got %h", want.first_word, got.first_word);
						errors++;
					end
					if (got.second_word !== want.second_word) begin
						$error("second_word: expected %h, got %h",
							want.second_word, got.second_word);
						errors++;
					end
					if (got.frame_length !== want.frame_length) begin
						$error("frame_length: expected %0d, got %0d",
							want.frame_length, got.frame_length);
						errors++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				made = classify_byte(frame_bytes_q[stim_pos].rx_byte,
					frame_bytes_q[stim_pos].last_byte, calc);
				if (made)
					pending_class_q.push_back(frame_bytes_q[stim_pos].typed ?
						frame_bytes_q[stim_pos].want : calc);
				stim_pos++;
			end

			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;

			// idle the receiver more than the sender first, then the sender more, then run flat out
			phase     = (stim_pos * 3) / frame_bytes_q.size();
			send_idle = (phase == 0) ? 18 : (phase == 1) ? 46 : 0;
			recv_idle = (phase == 0) ? 46 : (phase == 1) ? 18 : 0;

			// hold a transaction that has not been taken yet
			if (!(s_tvalid && !s_tready)) begin
				send = (stim_pos < frame_bytes_q.size()) &&
					($urandom_range(0, 99) >= send_idle);
				s_tvalid <= send;
				if (send) begin
					s_tdata <= frame_bytes_q[stim_pos].rx_byte;
					s_tlast <= frame_bytes_q[stim_pos].last_byte;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Sample on the falling edge so the end of run sees settled state.
	always @(negedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("link_frame_rx_classifier_unit_tb: FAIL");
			$finish;
		end else if (stim_pos == frame_bytes_q.size() && pending_class_q.size() == 0) begin
			if (drain_count == DRAIN_CYCLES) begin
				if (errors == 0)
					$display("link_frame_rx_classifier_unit_tb: PASS");
				else
					$display("link_frame_rx_classifier_unit_tb: FAIL");
				$finish;
			end else begin
				drain_count++;
			end
		end
	end

endmodule
